### sv/ctm_pkg.sv
package ctm_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int HOLD_MAX    = 11;
    localparam int HOLD_AW     = $clog2(HOLD_MAX);
    localparam int HOLD_CW     = $clog2(HOLD_MAX + 1);
    localparam int ALPHA_SHIFT = 16;
    localparam logic [12:0] ALPHA_RECIP = 13'd4370;
    localparam int CFG_AW      = 4;

    localparam logic [HOLD_CW-1:0] OPEN_LAST_FIXED = HOLD_CW'(6);
    localparam logic [HOLD_CW-1:0] OPEN_LAST_HEX   = HOLD_CW'(10);
    localparam logic [HOLD_CW-1:0] CLOSE_TAIL      = HOLD_CW'(7);

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [1:0] REG_BASE_RED   = 2'd0;
    localparam logic [1:0] REG_BASE_GREEN = 2'd1;
    localparam logic [1:0] REG_BASE_BLUE  = 2'd2;
    localparam logic [1:0] REG_BASE_ALPHA = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_DIV
    } t_state;

    function automatic logic [7:0] open_char(input logic [HOLD_CW-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            HOLD_CW'(0): c = CH_LBRACK;
            HOLD_CW'(1): c = CH_C;
            HOLD_CW'(2): c = CH_O;
            HOLD_CW'(3): c = CH_L;
            HOLD_CW'(4): c = CH_O;
            HOLD_CW'(5): c = CH_R;
            HOLD_CW'(6): c = CH_EQ;
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_char(input logic [HOLD_CW-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            HOLD_CW'(0): c = CH_LBRACK;
            HOLD_CW'(1): c = CH_SLASH;
            HOLD_CW'(2): c = CH_C;
            HOLD_CW'(3): c = CH_O;
            HOLD_CW'(4): c = CH_L;
            HOLD_CW'(5): c = CH_O;
            HOLD_CW'(6): c = CH_R;
            HOLD_CW'(7): c = CH_RBRACK;
            default:     c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [3:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 4'(b - 8'h57);
        end else begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

endpackage

### sv/color_tag_markup_parser.sv
// Strips "[color=RGBA]" and "[/color]" markup from a byte stream and tags every
// surviving byte with the tint in force, a line feed flag and a visible flag.
// Registers base_red/green/blue/alpha (APB, byte addresses 0x0, 0x4, 0x8, 0xC)
// give the starting tint of each text, loaded by its first byte; base_alpha
// also scales tag alpha as nibble*base_alpha/15. A plain byte is accepted, then
// its item is placed in the output register from S_FLUSH. A byte held as part
// of a possible tag, or a completed close tag, is consumed on acceptance and
// leaves the parser idle. A completed color tag is accepted, then in S_DIV the
// scaled alpha is divided by 15 through a reciprocal multiply. A broken tag or
// an end of text with bytes held replays them at one item per cycle while the
// output side does not stall. last_of_run marks the final item of each input.
// Input is not taken while a sequence is in progress; the output register lets
// the next input in while the last item still waits.
module color_tag_markup_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ctm_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_end_of_text,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_out_byte,
    output logic [7:0]                o_tint_red,
    output logic [7:0]                o_tint_green,
    output logic [7:0]                o_tint_blue,
    output logic [7:0]                o_tint_alpha,
    output logic                      o_is_newline,
    output logic                      o_visible,
    output logic                      o_last_of_run
);
    import ctm_pkg::*;

    t_state r_state, n_state;

    logic [7:0] r_base_red, r_base_green, r_base_blue, r_base_alpha;
    logic [7:0] r_tint_r, r_tint_g, r_tint_b, r_tint_a;
    logic [7:0] n_tint_r, n_tint_g, n_tint_b, n_tint_a;
    logic [31:0] r_stack [STACK_DEPTH];
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [7:0] r_held [HOLD_MAX];
    logic [HOLD_CW-1:0] r_held_count, n_held_count;
    logic r_is_close, n_is_close;
    logic r_fresh, n_fresh;
    logic [7:0] r_byte, n_byte;
    logic r_tail, n_tail;
    logic r_rehold, n_rehold;
    logic r_eot, n_eot;
    logic [HOLD_CW-1:0] r_idx, n_idx;
    logic [11:0] r_div_x, n_div_x;

    logic r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic [7:0] r_out_r, r_out_g, r_out_b, r_out_a;
    logic r_out_nl, r_out_vis, r_out_last, n_out_last;
    logic out_load;

    logic stack_we;
    logic held_we;
    logic [HOLD_AW-1:0] held_waddr;

    logic cfg_we;
    logic in_acc;
    logic slot_free;
    logic emit_held;
    logic [LEVEL_W-1:0] lvl_m1;
    logic [11:0] alpha_prod;
    logic [24:0] alpha_scaled;
    logic [3:0] hex_r, hex_g, hex_b, hex_a;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign slot_free = !r_out_valid || i_ready;
    assign lvl_m1  = r_level - LEVEL_W'(1);
    assign hex_r   = hex_val(r_held[7]);
    assign hex_g   = hex_val(r_held[8]);
    assign hex_b   = hex_val(r_held[9]);
    assign hex_a   = hex_val(r_held[10]);
    assign alpha_prod   = 12'(hex_a) * 12'(r_base_alpha);
    assign alpha_scaled = 25'(r_div_x) * 25'(ALPHA_RECIP);
    assign emit_held = r_idx < r_held_count;

    always_comb begin
        unique case (paddr[3:2])
            REG_BASE_RED:   prdata = {24'd0, r_base_red};
            REG_BASE_GREEN: prdata = {24'd0, r_base_green};
            REG_BASE_BLUE:  prdata = {24'd0, r_base_blue};
            REG_BASE_ALPHA: prdata = {24'd0, r_base_alpha};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_red   <= 8'd0;
            r_base_green <= 8'd0;
            r_base_blue  <= 8'd0;
            r_base_alpha <= 8'hFF;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_BASE_RED:   r_base_red   <= pwdata[7:0];
                REG_BASE_GREEN: r_base_green <= pwdata[7:0];
                REG_BASE_BLUE:  r_base_blue  <= pwdata[7:0];
                REG_BASE_ALPHA: r_base_alpha <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_tint_r     = r_tint_r;
        n_tint_g     = r_tint_g;
        n_tint_b     = r_tint_b;
        n_tint_a     = r_tint_a;
        n_level      = r_level;
        n_held_count = r_held_count;
        n_is_close   = r_is_close;
        n_fresh      = r_fresh;
        n_byte       = r_byte;
        n_tail       = r_tail;
        n_rehold     = r_rehold;
        n_eot        = r_eot;
        n_idx        = r_idx;
        n_div_x      = r_div_x;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_byte   = r_byte;
        n_out_last   = 1'b0;
        out_load     = 1'b0;
        stack_we     = 1'b0;
        held_we      = 1'b0;
        held_waddr   = r_held_count[HOLD_AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_byte = i_text_byte;
                    n_idx  = '0;
                    n_eot  = 1'b0;
                    if (i_end_of_text) begin
                        if (r_held_count != '0) begin
                            n_state  = S_FLUSH;
                            n_tail   = 1'b0;
                            n_rehold = 1'b0;
                            n_eot    = 1'b1;
                        end else begin
                            n_fresh = 1'b1;
                            n_level = '0;
                        end
                    end else begin
                        if (r_fresh) begin
                            n_tint_r = r_base_red;
                            n_tint_g = r_base_green;
                            n_tint_b = r_base_blue;
                            n_tint_a = r_base_alpha;
                            n_level  = '0;
                            n_fresh  = 1'b0;
                        end
                        if (r_held_count == '0) begin
                            if (i_text_byte == CH_LBRACK) begin
                                held_we      = 1'b1;
                                n_held_count = HOLD_CW'(1);
                            end else begin
                                n_state  = S_FLUSH;
                                n_tail   = 1'b1;
                                n_rehold = 1'b0;
                            end
                        end else if (r_held_count == HOLD_CW'(1) &&
                                     (i_text_byte == CH_C || i_text_byte == CH_SLASH)) begin
                            held_we      = 1'b1;
                            n_held_count = r_held_count + HOLD_CW'(1);
                            n_is_close   = (i_text_byte == CH_SLASH);
                        end else if (r_held_count != HOLD_CW'(1) && !r_is_close &&
                                     r_held_count <= OPEN_LAST_FIXED &&
                                     i_text_byte == open_char(r_held_count)) begin
                            held_we      = 1'b1;
                            n_held_count = r_held_count + HOLD_CW'(1);
                        end else if (!r_is_close && r_held_count > OPEN_LAST_FIXED &&
                                     r_held_count <= OPEN_LAST_HEX &&
                                     is_hex(i_text_byte)) begin
                            held_we      = 1'b1;
                            n_held_count = r_held_count + HOLD_CW'(1);
                        end else if (!r_is_close && r_held_count > OPEN_LAST_HEX &&
                                     i_text_byte == CH_RBRACK) begin
                            // complete color tag: push if the stack has room, set color, start alpha scaling
                            stack_we     = r_level < LEVEL_W'(STACK_DEPTH);
                            n_level      = stack_we ? r_level + LEVEL_W'(1) : r_level;
                            n_tint_r     = {hex_r, hex_r};
                            n_tint_g     = {hex_g, hex_g};
                            n_tint_b     = {hex_b, hex_b};
                            n_div_x      = alpha_prod;
                            n_held_count = '0;
                            n_state      = S_DIV;
                        end else if (r_held_count != HOLD_CW'(1) && r_is_close &&
                                     r_held_count < CLOSE_TAIL &&
                                     i_text_byte == close_char(r_held_count)) begin
                            held_we      = 1'b1;
                            n_held_count = r_held_count + HOLD_CW'(1);
                        end else if (r_is_close && r_held_count == CLOSE_TAIL &&
                                     i_text_byte == CH_RBRACK) begin
                            if (r_level != '0) begin
                                {n_tint_r, n_tint_g, n_tint_b, n_tint_a} =
                                    r_stack[lvl_m1[STACK_AW-1:0]];
                                n_level = lvl_m1;
                            end
                            n_held_count = '0;
                        end else begin
                            n_state  = S_FLUSH;
                            n_tail   = (i_text_byte != CH_LBRACK);
                            n_rehold = (i_text_byte == CH_LBRACK);
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (slot_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + HOLD_CW'(1);
                    if (emit_held) begin
                        n_out_byte = r_held[r_idx[HOLD_AW-1:0]];
                        n_out_last = (r_idx == r_held_count - HOLD_CW'(1)) && !r_tail;
                    end else begin
                        n_out_byte = r_byte;
                        n_out_last = 1'b1;
                    end
                    if (n_out_last) begin
                        n_state      = S_IDLE;
                        n_held_count = r_rehold ? HOLD_CW'(1) : '0;
                        if (r_eot) begin
                            n_fresh = 1'b1;
                            n_level = '0;
                        end
                    end
                end
            end
            S_DIV: begin
                n_tint_a = alpha_scaled[ALPHA_SHIFT +: 8];
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= '0;
            r_held_count <= '0;
            r_fresh      <= 1'b1;
            r_out_valid  <= 1'b0;
            r_is_close   <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_level      <= n_level;
            r_held_count <= n_held_count;
            r_fresh      <= n_fresh;
            r_out_valid  <= n_out_valid;
            r_is_close   <= n_is_close;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tint_r  <= n_tint_r;
        r_tint_g  <= n_tint_g;
        r_tint_b  <= n_tint_b;
        r_tint_a  <= n_tint_a;
        r_byte    <= n_byte;
        r_tail    <= n_tail;
        r_rehold  <= n_rehold;
        r_eot     <= n_eot;
        r_div_x   <= n_div_x;
        if (stack_we) begin
            r_stack[r_level[STACK_AW-1:0]] <= {r_tint_r, r_tint_g, r_tint_b, r_tint_a};
        end
        if (held_we) begin
            r_held[held_waddr] <= i_text_byte;
        end
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_r    <= r_tint_r;
            r_out_g    <= r_tint_g;
            r_out_b    <= r_tint_b;
            r_out_a    <= r_tint_a;
            r_out_nl   <= (n_out_byte == CH_LF);
            r_out_vis  <= !(n_out_byte == CH_SP || n_out_byte == CH_TAB ||
                            n_out_byte == CH_LF);
            r_out_last <= n_out_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_tint_red    = r_out_r;
    assign o_tint_green  = r_out_g;
    assign o_tint_blue   = r_out_b;
    assign o_tint_alpha  = r_out_a;
    assign o_is_newline  = r_out_nl;
    assign o_visible     = r_out_vis;
    assign o_last_of_run = r_out_last;

`ifndef SYNTH
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count <= HOLD_CW'(HOLD_MAX))
        else $error("held byte count out of range");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_W'(STACK_DEPTH))
        else $error("stack level out of range");

    a_out_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FLUSH))
        else $error("item issued outside replay sequence");

    a_eot_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_end_of_text) |=> (r_fresh || r_state == S_FLUSH))
        else $error("end of text neither flushed nor restarted the text");

    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_IDLE))
        else $error("alpha scaling took more than one cycle");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import ctm_pkg::*;

    localparam int OPEN_FIXED   = 7;
    localparam int OPEN_HEX_END = 11;
    localparam int OPEN_LEN     = 12;
    localparam int CLOSE_LEN    = 8;
    localparam int MAX_RUN      = 12;
    localparam int STACK_FILL   = STACK_DEPTH + 1;
    localparam int RANDOM_END   = 320;
    localparam int IDLE_PAD     = 24;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [7:0] CH_ZERO    = "0";
    localparam logic [7:0] CH_LOWER_A = "a";
    localparam logic [7:0] CH_UPPER_A = "A";

    localparam logic [7:0] OPEN_SEQ [OPEN_FIXED] =
        '{CH_LBRACK, CH_C, CH_O, CH_L, CH_O, CH_R, CH_EQ};
    localparam logic [7:0] CLOSE_SEQ [CLOSE_LEN] =
        '{CH_LBRACK, CH_SLASH, CH_C, CH_O, CH_L, CH_O, CH_R, CH_RBRACK};
    localparam logic [1:0] BASE_REGS [4] =
        '{REG_BASE_RED, REG_BASE_GREEN, REG_BASE_BLUE, REG_BASE_ALPHA};

    typedef enum int {TAG_NONE, TAG_PARTIAL, TAG_COLOR, TAG_CLOSE} t_tag_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       newline;
        logic       vis;
        logic       last;
    } t_glyph;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic [7:0]          i_text_byte;
    logic                i_end_of_text;
    logic                o_valid;
    logic                i_ready;
    logic [7:0]          o_out_byte;
    logic [7:0]          o_tint_red;
    logic [7:0]          o_tint_green;
    logic [7:0]          o_tint_blue;
    logic [7:0]          o_tint_alpha;
    logic                o_is_newline;
    logic                o_visible;
    logic                o_last_of_run;

    color_tag_markup_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_tint_red    (o_tint_red),
        .o_tint_green  (o_tint_green),
        .o_tint_blue   (o_tint_blue),
        .o_tint_alpha  (o_tint_alpha),
        .o_is_newline  (o_is_newline),
        .o_visible     (o_visible),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tint tracking state
    logic [7:0]  base_r, base_g, base_b, base_a;
    logic [31:0] tint;
    logic [31:0] tint_stack [STACK_DEPTH];
    int          tint_depth;
    logic [7:0]  hold_buf [HOLD_MAX];
    int          hold_cnt;
    bit          text_start;

    t_glyph      pending_glyphs [$];
    t_glyph      step_glyphs [$];
    logic [7:0]  replay_bytes [$];

    int          error_count;
    int          cycle_count;
    int          item_count;
    int          burst_left;
    bit          tx_gaps;
    bit          rx_stalls;
    bit          rx_state;
    int          rx_left;

    task automatic report_error(input string msg);
        $display("ERROR cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'(CH_ZERO);
        if (c >= "a" && c <= "f") return int'(c) - int'(CH_LOWER_A) + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'(CH_UPPER_A) + 10;
        return -1;
    endfunction

    function automatic void emit_glyph(input logic [7:0] c);
        t_glyph g;
        if (step_glyphs.size() >= MAX_RUN) return;
        g.ch      = c;
        g.red     = tint[31:24];
        g.green   = tint[23:16];
        g.blue    = tint[15:8];
        g.alpha   = tint[7:0];
        g.newline = (c == CH_LF);
        g.vis     = !(c == CH_SP || c == CH_TAB || c == CH_LF);
        g.last    = 1'b0;
        step_glyphs.push_back(g);
    endfunction

    function automatic t_tag_kind classify_tag(input logic [7:0] cand [HOLD_MAX+1],
                                               input int len);
        bit op;
        bit cl;
        int i;
        op = (len <= OPEN_LEN);
        cl = (len <= CLOSE_LEN);
        for (i = 0; i < len; i++) begin
            if (op) begin
                if (i < OPEN_FIXED) begin
                    op = (cand[i] == OPEN_SEQ[i]);
                end else if (i < OPEN_HEX_END) begin
                    op = (nibble_of(cand[i]) >= 0);
                end else begin
                    op = (cand[i] == CH_RBRACK);
                end
            end
            if (cl && i < CLOSE_LEN) cl = (cand[i] == CLOSE_SEQ[i]);
        end
        if (op && len == OPEN_LEN) return TAG_COLOR;
        if (cl && len == CLOSE_LEN) return TAG_CLOSE;
        return (op || cl) ? TAG_PARTIAL : TAG_NONE;
    endfunction

    function automatic void apply_color(input logic [7:0] cand [HOLD_MAX+1]);
        int r;
        int g;
        int b;
        int a;
        r = nibble_of(cand[7]) * 17;
        g = nibble_of(cand[8]) * 17;
        b = nibble_of(cand[9]) * 17;
        a = nibble_of(cand[10]) * 17 * int'(base_a) / 255;
        if (tint_depth < STACK_DEPTH) begin
            tint_stack[tint_depth] = tint;
            tint_depth++;
        end
        tint = {8'(r), 8'(g), 8'(b), 8'(a)};
    endfunction

    // process replay_bytes in order; a broken tag re-queues its tail at the front
    function automatic void parse_bytes();
        logic [7:0] cand [HOLD_MAX+1];
        logic [7:0] c;
        int         len;
        int         i;
        t_tag_kind  kind;
        while (replay_bytes.size() > 0) begin
            c = replay_bytes.pop_front();
            if (hold_cnt == 0) begin
                if (c == CH_LBRACK) begin
                    hold_buf[0] = c;
                    hold_cnt = 1;
                end else begin
                    emit_glyph(c);
                end
            end else begin
                for (i = 0; i < hold_cnt; i++) cand[i] = hold_buf[i];
                cand[hold_cnt] = c;
                len = hold_cnt + 1;
                kind = classify_tag(cand, len);
                if (kind == TAG_COLOR) begin
                    apply_color(cand);
                    hold_cnt = 0;
                end else if (kind == TAG_CLOSE) begin
                    if (tint_depth > 0) begin
                        tint_depth--;
                        tint = tint_stack[tint_depth];
                    end
                    hold_cnt = 0;
                end else if (kind == TAG_PARTIAL && len <= HOLD_MAX) begin
                    hold_buf[hold_cnt] = c;
                    hold_cnt++;
                end else begin
                    hold_cnt = 0;
                    emit_glyph(cand[0]);
                    for (i = len - 1; i >= 1; i--) replay_bytes.push_front(cand[i]);
                end
            end
        end
    endfunction

    function automatic void predict_glyphs(input logic [7:0] b, input logic eot);
        logic [7:0] held [HOLD_MAX];
        int         cnt;
        int         i;
        t_glyph     g;
        step_glyphs.delete();
        if (eot) begin
            while (hold_cnt > 0) begin
                cnt = hold_cnt;
                for (i = 0; i < cnt; i++) held[i] = hold_buf[i];
                hold_cnt = 0;
                emit_glyph(held[0]);
                for (i = 1; i < cnt; i++) replay_bytes.push_back(held[i]);
                parse_bytes();
            end
            tint = {base_r, base_g, base_b, base_a};
            tint_depth = 0;
            text_start = 1'b1;
        end else begin
            if (text_start) begin
                tint = {base_r, base_g, base_b, base_a};
                tint_depth = 0;
                text_start = 1'b0;
            end
            replay_bytes.push_back(b);
            parse_bytes();
        end
        if (step_glyphs.size() > 0) begin
            g = step_glyphs.pop_back();
            g.last = 1'b1;
            step_glyphs.push_back(g);
        end
        foreach (step_glyphs[i]) pending_glyphs.push_back(step_glyphs[i]);
    endfunction

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %02h expected %02h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_glyphs.size() == 0) begin
                report_error($sformatf("unexpected item byte %02h", o_out_byte));
            end else begin
                want = pending_glyphs.pop_front();
                check_field("out_byte", o_out_byte, want.ch);
                check_field("tint_red", o_tint_red, want.red);
                check_field("tint_green", o_tint_green, want.green);
                check_field("tint_blue", o_tint_blue, want.blue);
                check_field("tint_alpha", o_tint_alpha, want.alpha);
                check_field("is_newline", 8'(o_is_newline), 8'(want.newline));
                check_field("visible", 8'(o_visible), 8'(want.vis));
                check_field("last_of_run", 8'(o_last_of_run), 8'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: always ready, or with rx_stalls alternate runs of ready and stall
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            i_ready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_state = !rx_state;
                rx_left = rx_state ? $urandom_range(1, 10) : $urandom_range(1, 6);
            end
            rx_left--;
            i_ready <= rx_state;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (tx_gaps) begin
                @(negedge i_clk) i_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_glyphs(b, eot);
        item_count++;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_text_byte();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return CH_LBRACK;
        if (pick == 1) return CH_SP;
        if (pick == 2) return CH_TAB;
        if (pick == 3) return CH_LF;
        if (pick == 4) return 8'h00;
        if (pick == 5) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // send the first n_bytes of a well-formed color or close tag
    task automatic send_tag(input bit is_open, input int n_bytes);
        logic [7:0] seq [OPEN_LEN];
        int         nib;
        int         i;
        if (is_open) begin
            for (i = 0; i < OPEN_FIXED; i++) seq[i] = OPEN_SEQ[i];
            for (i = OPEN_FIXED; i < OPEN_HEX_END; i++) begin
                nib = $urandom_range(0, 15);
                if (nib < 10) begin
                    seq[i] = 8'(int'(CH_ZERO) + nib);
                end else if ($urandom_range(0, 1)) begin
                    seq[i] = 8'(int'(CH_UPPER_A) + nib - 10);
                end else begin
                    seq[i] = 8'(int'(CH_LOWER_A) + nib - 10);
                end
            end
            seq[OPEN_HEX_END] = CH_RBRACK;
        end else begin
            for (i = 0; i < CLOSE_LEN; i++) seq[i] = CLOSE_SEQ[i];
        end
        for (i = 0; i < n_bytes; i++) send_byte(seq[i], 1'b0);
    endtask

    task automatic send_broken_tag();
        bit is_open;
        is_open = $urandom_range(0, 1);
        send_tag(is_open, $urandom_range(1, is_open ? OPEN_LEN - 1 : CLOSE_LEN - 1));
    endtask

    task automatic send_random_text();
        int segs;
        int pick;
        int n;
        int s;
        if ($urandom_range(0, 3) == 0) send_tag(1'b0, CLOSE_LEN);
        segs = $urandom_range(1, 6);
        for (s = 0; s < segs; s++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                repeat ($urandom_range(1, 5)) send_byte(rand_text_byte(), 1'b0);
            end else if (pick < 5) begin
                send_tag(1'b1, OPEN_LEN);
            end else if (pick < 7) begin
                send_tag(1'b0, CLOSE_LEN);
            end else if (pick < 9) begin
                send_broken_tag();
                send_byte(rand_text_byte(), 1'b0);
            end else begin
                n = $urandom_range(2, 4);
                repeat (n) send_tag(1'b1, OPEN_LEN);
                send_byte(rand_text_byte(), 1'b0);
                repeat (n) send_tag(1'b0, CLOSE_LEN);
            end
        end
        pick = $urandom_range(0, 9);
        if (pick >= 2) begin
            if (pick < 4) send_broken_tag();
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            if (pick == 4) send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic drain_glyphs();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic write_base_reg(input logic [1:0] reg_id, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CFG_AW'({reg_id, 2'b00});
        pwdata  <= {24'h0, val};
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (reg_id)
            REG_BASE_RED:   base_r = val;
            REG_BASE_GREEN: base_g = val;
            REG_BASE_BLUE:  base_b = val;
            REG_BASE_ALPHA: base_a = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk) psel <= 1'b1;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {24'h0, val}) begin
            report_error($sformatf("register %0d read %08h expected %02h", reg_id, prdata,
                                   val));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    task automatic test_color_tag();
        send_string("[color=Ff0a]");
    endtask

    task automatic test_broken_tag();
        send_string("[/cx");
    endtask

    task automatic test_end_of_text();
        send_string("[co");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_stack_full();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (STACK_FILL) begin
            send_tag(1'b1, OPEN_LEN);
            if ($urandom_range(0, 2) == 0) send_byte(rand_text_byte(), 1'b0);
        end
        send_byte(rand_text_byte(), 1'b0);
        repeat (2) send_tag(1'b0, CLOSE_LEN);
        send_byte(rand_text_byte(), 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_texts();
        while (item_count < RANDOM_END) begin
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            send_random_text();
        end
    endtask

    task automatic test_register_settings();
        logic [7:0] vals [4];
        int         phase;
        int         r;
        for (phase = 0; phase < 5; phase++) begin
            for (r = 0; r < 4; r++) begin
                if (phase == 0) vals[r] = 8'h00;
                else if (phase == 1) vals[r] = 8'hFF;
                else vals[r] = 8'($urandom_range(0, 255));
            end
            drain_glyphs();
            for (r = 0; r < 4; r++) write_base_reg(BASE_REGS[r], vals[r]);
            tx_gaps   = phase[0];
            rx_stalls = phase > 1;
            send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_tag(1'b1, OPEN_LEN);
            repeat (3) send_byte(rand_text_byte(), 1'b0);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_text_byte   = 8'h00;
        i_end_of_text = 1'b0;
        i_ready       = 1'b0;
        base_r        = 8'h00;
        base_g        = 8'h00;
        base_b        = 8'h00;
        base_a        = 8'hFF;
        tint          = {base_r, base_g, base_b, base_a};
        tint_depth    = 0;
        hold_cnt      = 0;
        text_start    = 1'b1;
        error_count   = 0;
        cycle_count   = 0;
        item_count    = 0;
        burst_left    = 0;
        tx_gaps       = 1'b0;
        rx_stalls     = 1'b0;
        rx_state      = 1'b0;
        rx_left       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_plain_bytes();
        test_color_tag();
        test_broken_tag();
        test_end_of_text();
        test_stack_full();
        test_random_texts();
        test_register_settings();

        drain_glyphs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
